/* rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int WORD_BITS = 32;
  localparam logic [WORD_BITS-1:0] WORD_FULL = 32'hFFFF_FFFF;
  localparam logic [15:0] TOTAL_RESET = 16'd32768;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int PADDR_W = 27;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  // Result status codes carried on the output tuser
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_OOM    = 2'd1;
  localparam logic [1:0] STAT_BEYOND = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_MODIFY,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Search unit status towards the controller
  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

  // Summary update from the controller, one per map write
  typedef struct packed {
    logic en;
    logic avail;
  } summ_upd_t;

  // Lowest set bit of a word (zero when none)
  function automatic logic [4:0] lowest_set32(input logic [WORD_BITS-1:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  // Ones in the bits below n
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [4:0] n);
    return ~(WORD_FULL << n);
  endfunction

endpackage

/* rtl/bpa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bpa_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_search
// Per-word availability summary and two-level search for the lowest map
// word below the limit that still has a clear bit.
// ----------------------------------------------------------------------------
module bpa_search
  import bpa_pkg::*;
#(
  parameter int MAP_WORDS = 1024
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic [$clog2(MAP_WORDS + 1)-1:0]               limit,
  input  summ_upd_t                                      upd,
  input  logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] upd_addr,
  output srch_stat_t                                     stat,
  output logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] word
);

  localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int GROUPS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IDX_W  = GRP_W + 5;

  logic [GROUPS*WORD_BITS-1:0] avail;
  logic [GROUPS-1:0]           grp_any;
  logic [GROUPS-1:0]           grp_any_c;
  logic [GRP_W-1:0]            grp_sel_c;
  logic [GRP_W-1:0]            sel_grp;
  logic                        sel_found;
  logic                        v1;
  logic                        v2;
  logic [15:0]                 lim16;
  logic [10:0]                 lim_grp;
  logic [4:0]                  lim_bit;
  logic [WORD_BITS-1:0]        word_bits;
  logic [WORD_BITS-1:0]        word_mask;
  logic [IDX_W-1:0]            word_c;

  assign lim16   = 16'(limit);
  assign lim_grp = lim16[15:5];
  assign lim_bit = lim16[4:0];

  // Summary: a set bit means the word has a clear page
  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
    end else if (upd.en) begin
      avail[IDX_W'(upd_addr)] <= upd.avail;
    end
  end

  // Stage one: per-group any-available under the limit
  always_comb begin
    logic [WORD_BITS-1:0] gm;
    gm = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (11'(g) < lim_grp) begin
        gm = WORD_FULL;
      end else if (11'(g) == lim_grp) begin
        gm = low_mask(lim_bit);
      end else begin
        gm = '0;
      end
      grp_any_c[g] = |(avail[g*WORD_BITS +: WORD_BITS] & gm);
    end
  end

  // Stage two: lowest group with an available word
  always_comb begin
    grp_sel_c = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel_c = GRP_W'(g);
      end
    end
  end

  // Stage three: lowest available word inside that group
  always_comb begin
    word_bits = avail[{sel_grp, 5'b0} +: WORD_BITS];
    if (11'(sel_grp) < lim_grp) begin
      word_mask = WORD_FULL;
    end else if (11'(sel_grp) == lim_grp) begin
      word_mask = low_mask(lim_bit);
    end else begin
      word_mask = '0;
    end
    word_c = {sel_grp, lowest_set32(word_bits & word_mask)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      stat.done  <= 1'b0;
      stat.found <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      stat.done <= v2;
      if (v2) begin
        stat.found <= sel_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      grp_any <= grp_any_c;
    end
    if (v1) begin
      sel_grp   <= grp_sel_c;
      sel_found <= |grp_any;
    end
    if (v2) begin
      word <= word_c[WORD_W-1:0];
    end
  end

endmodule

/* rtl/bitmap_page_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Bitmap page frame allocator: a used map of one bit per page held in a
// word-wide RAM, a used-page count, and a summary-driven search for
// allocation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer when            Carries
//  -------  ---------  -----------------------  -------------------------------
//  s_*      in         s_tvalid & s_tready      opcode, byte address
//  m_*      out        m_tvalid & m_tready      status, page address, counts
//  cfg_*    in         cfg_wen                  total_blocks
//
//  Free and mark-used go through acceptance, RAM read, read-modify-write
//  and result load; allocate first runs the summary search pipeline.
//  Init makes one RAM write per covered word before its result load.
//  After reset a clearing pass writes all ones to every map word while
//  s_tready stays low; configuration writes are still taken.
//  One transaction is in flight at a time; a result waiting on m_tready
//  holds the controller only once the next result is ready to load.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAP_WORDS  = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] byte_addr
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [26:0] page_addr, [42:27] used_count,
                                 // [58:43] free_count, [63:59] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // Configuration
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata  // total_blocks
);

  localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W  = $clog2(MAP_WORDS + 1);
  localparam logic [32:0] MAP_PAGES = 33'(MAP_WORDS) << 5;

  state_t state;
  state_t state_next;

  logic [15:0]          total_blocks;
  logic [15:0]          used_pages;
  logic [1:0]           op;
  logic [WORD_W-1:0]    word_idx;
  logic [4:0]           bit_idx;
  logic [CNT_W-1:0]     sweep_cnt;
  logic [CNT_W-1:0]     sweep_limit;
  logic [1:0]           res_status;
  logic [PADDR_W-1:0]   res_paddr;

  logic                 s_accept;
  logic                 out_load;
  logic                 sweep_last;
  logic [15:0]          words_total;
  logic [15:0]          n16;
  logic [CNT_W-1:0]     n_words;
  logic [32:0]          in_page;
  logic                 in_beyond;

  logic                 ram_we;
  logic [WORD_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 srch_start;
  srch_stat_t           srch_stat;
  logic [WORD_W-1:0]    srch_word;
  summ_upd_t            summ_upd;

  logic [4:0]           mod_bit;
  logic [WORD_BITS-1:0] mod_mask;
  logic                 mod_cur;
  logic [WORD_BITS-1:0] mod_word;
  logic [63:0]          alloc_paddr;
  logic [15:0]          free_pages;

  // Words covered by allocate and init: floor(total/32), capped at the map
  assign words_total = {5'b0, total_blocks[15:5]};
  assign n16         = (words_total > 16'(MAP_WORDS)) ? 16'(MAP_WORDS) : words_total;
  assign n_words     = n16[CNT_W-1:0];

  assign in_page     = 33'(s_tdata) >> PAGE_SHIFT;
  assign in_beyond   = in_page >= MAP_PAGES;

  assign s_accept    = s_tvalid && s_tready;
  assign sweep_last  = (sweep_cnt + CNT_W'(1)) == sweep_limit;

  // ---- next state ---------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_accept) begin
          unique case (s_tuser)
            OP_ALLOC: state_next = ST_SEARCH;
            OP_FREE,
            OP_MARK:  state_next = in_beyond ? ST_DONE : ST_READ;
            OP_INIT:  state_next = (n_words == '0) ? ST_DONE : ST_SWEEP;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (srch_stat.done) state_next = srch_stat.found ? ST_READ : ST_DONE;
      end
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_DONE;
      ST_SWEEP: begin
        if (sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---- state outputs ------------------------------------------------------
  always_comb begin
    s_tready   = (state == ST_IDLE);
    srch_start = (state == ST_IDLE) && s_accept && (s_tuser == OP_ALLOC);
    ram_re     = (state == ST_READ);
    ram_we     = 1'b0;
    ram_waddr  = word_idx;
    ram_wdata  = mod_word;
    out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
    unique case (state)
      ST_CLEAR, ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt[WORD_W-1:0];
        ram_wdata = WORD_FULL;
      end
      ST_MODIFY: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    summ_upd.en    = ram_we;
    summ_upd.avail = (ram_wdata != WORD_FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // ---- read-modify-write of one map word ----------------------------------
  // Allocate takes the lowest clear bit; free and mark use the page's bit
  always_comb begin
    mod_bit  = (op == OP_ALLOC) ? lowest_set32(~ram_rdata) : bit_idx;
    mod_mask = WORD_BITS'(1) << mod_bit;
    mod_cur  = |(ram_rdata & mod_mask);
    mod_word = (op == OP_FREE) ? (ram_rdata & ~mod_mask) : (ram_rdata | mod_mask);
  end

  assign alloc_paddr = 64'({word_idx, mod_bit}) << PAGE_SHIFT;
  assign free_pages  = (total_blocks > used_pages) ? (total_blocks - used_pages) : 16'd0;

  // ---- control registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= TOTAL_RESET;
      used_pages   <= TOTAL_RESET;
      sweep_cnt    <= '0;
      sweep_limit  <= CNT_W'(MAP_WORDS);
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        total_blocks <= cfg_wdata;
      end
      // Advance the sweep; the counter parks at zero between sweeps
      if (state == ST_CLEAR || state == ST_SWEEP) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + CNT_W'(1);
      end
      if (s_accept && s_tuser == OP_INIT) begin
        sweep_limit <= n_words;
        if (n_words == '0) used_pages <= total_blocks;
      end
      if (state == ST_SWEEP && sweep_last) begin
        used_pages <= total_blocks;
      end
      // Count only a bit that changes, saturating at both ends
      if (state == ST_MODIFY) begin
        if (op == OP_FREE) begin
          if (mod_cur && used_pages != 16'd0) used_pages <= used_pages - 16'd1;
        end else begin
          if (!mod_cur && used_pages != COUNT_MAX) used_pages <= used_pages + 16'd1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---- payload registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op        <= s_tuser;
      word_idx  <= in_page[WORD_W+4:5];
      bit_idx   <= in_page[4:0];
      res_paddr <= '0;
      res_status <= ((s_tuser == OP_FREE || s_tuser == OP_MARK) && in_beyond)
                    ? STAT_BEYOND : STAT_OK;
    end
    if (state == ST_SEARCH && srch_stat.done) begin
      if (srch_stat.found) begin
        word_idx <= srch_word;
      end else begin
        res_status <= STAT_OOM;
      end
    end
    if (state == ST_MODIFY && op == OP_ALLOC) begin
      res_paddr <= alloc_paddr[PADDR_W-1:0];
    end
    // Hold the result until taken; the counts are final once in ST_DONE
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {5'b0, free_pages, used_pages, res_paddr};
    end
  end

  // ---- map storage and search ---------------------------------------------
  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (word_idx),
    .rdata (ram_rdata)
  );

  bpa_search #(
    .MAP_WORDS (MAP_WORDS)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (srch_start),
    .limit    (n_words),
    .upd      (summ_upd),
    .upd_addr (ram_waddr),
    .stat     (srch_stat),
    .word     (srch_word)
  );

  // ---- assertions ---------------------------------------------------------
  // A map word never gets read and written in the same cycle
  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("map read and write overlap");

  // The summary must agree with the map: a word chosen for allocation has a clear bit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && op == OP_ALLOC) |-> (ram_rdata != WORD_FULL))
    else $error("allocation picked a full map word");

  // The used count only moves on a map update or the end of an init
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !s_accept) |=> $stable(used_pages))
    else $error("used count changed while idle");

  // No input is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input accepted during clearing pass");

endmodule
